/* rtl/rgb_led_wipe_fade_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_WIPE_FADE_SEQUENCER_DEFINES_SVH
`define RGB_LED_WIPE_FADE_SEQUENCER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds
`define RLWF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds
`define RLWF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/rlwf_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer package
// Widths, phase encoding, command word and defaults shared by all modules.
// ----------------------------------------------------------------------------
package rlwf_pkg;

    localparam int LED_IDX_W   = 6;
    localparam int LEVEL_W     = 8;
    localparam int TDIV_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam int LED_COUNT_DEF   = 38;
    localparam int TICK_DIVIDE_DEF = 10;
    localparam int CMD_DEPTH_DEF   = 2;

    localparam logic [LEVEL_W-1:0] FADE_PEAK_RST  = 8'd100;
    localparam logic [LEVEL_W-1:0] WIPE_LEVEL_RST = 8'd80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_PEAK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIPE_LEVEL = 1'b1;

    typedef enum logic [2:0] {
        PH_WIPE_R = 3'd0,
        PH_WIPE_G = 3'd1,
        PH_WIPE_B = 3'd2,
        PH_RAMP_R = 3'd3,
        PH_R2G    = 3'd4,
        PH_G2B    = 3'd5,
        PH_FADE_B = 3'd6,
        PH_DARK   = 3'd7
    } phase_t;

    // One action for the back end: a single LED or the whole string
    typedef struct packed {
        logic                 bcast;
        logic [LED_IDX_W-1:0] index;
        logic [LEVEL_W-1:0]   red;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   blue;
    } cmd_t;

endpackage

/* rtl/rlwf_front.sv */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer front end
// Divides ticks, walks the show phases and issues one command per action, except for the action that ends a wipe pass.
// ----------------------------------------------------------------------------
module rlwf_front #(
    parameter int LED_COUNT   = rlwf_pkg::LED_COUNT_DEF,
    parameter int TICK_DIVIDE = rlwf_pkg::TICK_DIVIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          tick,
    input  logic [rlwf_pkg::LEVEL_W-1:0]  fade_peak,
    input  logic [rlwf_pkg::LEVEL_W-1:0]  wipe_level,
    output logic                          cmd_push,
    output rlwf_pkg::cmd_t                cmd
);
    import rlwf_pkg::*;

    localparam int WPOS_W = $clog2(LED_COUNT + 1);

    function automatic logic [LEVEL_W-1:0] inc_sat(input logic [LEVEL_W-1:0] v);
        inc_sat = (v == {LEVEL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEVEL_W-1:0] dec_sat(input logic [LEVEL_W-1:0] v);
        dec_sat = (v == '0) ? v : v - 1'b1;
    endfunction

    logic [TDIV_W-1:0]  tdiv_reg, tdiv_next;
    phase_t             phase_reg, phase_next;
    logic [WPOS_W-1:0]  wpos_reg, wpos_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] green_reg, green_next;
    logic [LEVEL_W-1:0] blue_reg, blue_next;

    logic action;
    logic in_wipe;
    logic wipe_end;

    assign action   = accept && tick && (tdiv_reg == TDIV_W'(TICK_DIVIDE - 1));
    assign in_wipe  = (phase_reg == PH_WIPE_R) || (phase_reg == PH_WIPE_G) ||
                      (phase_reg == PH_WIPE_B);
    assign wipe_end = (wpos_reg >= WPOS_W'(LED_COUNT));

    // Next state: divider, phase, wipe position and fade levels
    always_comb
    begin
        tdiv_next  = tdiv_reg;
        phase_next = phase_reg;
        wpos_next  = wpos_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (accept && tick)
        begin
            tdiv_next = action ? '0 : tdiv_reg + 1'b1;
        end
        if (action)
        begin
            unique case (phase_reg)
                PH_WIPE_R, PH_WIPE_G, PH_WIPE_B:
                begin
                    if (wipe_end)
                    begin
                        phase_next = phase_t'(phase_reg + 3'd1);
                        wpos_next  = '0;
                    end
                    else
                    begin
                        wpos_next = wpos_reg + 1'b1;
                    end
                end
                PH_RAMP_R:
                begin
                    red_next = inc_sat(red_reg);
                    if (red_next >= fade_peak)
                        phase_next = PH_R2G;
                end
                PH_R2G:
                begin
                    red_next   = dec_sat(red_reg);
                    green_next = inc_sat(green_reg);
                    if (green_next >= fade_peak)
                        phase_next = PH_G2B;
                end
                PH_G2B:
                begin
                    green_next = dec_sat(green_reg);
                    blue_next  = inc_sat(blue_reg);
                    if (blue_next >= fade_peak)
                        phase_next = PH_FADE_B;
                end
                PH_FADE_B:
                begin
                    blue_next = dec_sat(blue_reg);
                    if (blue_next == '0)
                        phase_next = PH_DARK;
                end
                PH_DARK:
                begin
                    red_next   = '0;
                    green_next = '0;
                    blue_next  = '0;
                end
                default:
                begin
                    phase_next = PH_DARK;
                end
            endcase
        end
    end

    // Outputs: command word for the back end
    always_comb
    begin
        cmd_push  = action && !(in_wipe && wipe_end);
        cmd.bcast = !in_wipe;
        cmd.index = in_wipe ? LED_IDX_W'(wpos_reg) : '0;
        if (in_wipe)
        begin
            cmd.red   = (phase_reg == PH_WIPE_R) ? wipe_level : '0;
            cmd.green = (phase_reg == PH_WIPE_G) ? wipe_level : '0;
            cmd.blue  = (phase_reg == PH_WIPE_B) ? wipe_level : '0;
        end
        else
        begin
            cmd.red   = red_next;
            cmd.green = green_next;
            cmd.blue  = blue_next;
        end
    end

    // State registers: divider, phase, wipe position and fade levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tdiv_reg  <= '0;
            phase_reg <= PH_WIPE_R;
            wpos_reg  <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else
        begin
            tdiv_reg  <= tdiv_next;
            phase_reg <= phase_next;
            wpos_reg  <= wpos_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

/* rtl/rlwf_cmd_queue.sv */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer command queue
// Small first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module rlwf_cmd_queue #(
    parameter int DEPTH = rlwf_pkg::CMD_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rlwf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output rlwf_pkg::cmd_t head_cmd,
    output logic           empty
);
    import rlwf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/rlwf_back.sv */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer back end
// Expands each command into LED words in an output register, one per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module rlwf_back #(
    parameter int LED_COUNT = rlwf_pkg::LED_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rlwf_pkg::cmd_t                  head_cmd,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic [rlwf_pkg::LED_IDX_W-1:0]  led_index,
    output logic [rlwf_pkg::LEVEL_W-1:0]    red,
    output logic [rlwf_pkg::LEVEL_W-1:0]    green,
    output logic [rlwf_pkg::LEVEL_W-1:0]    blue,
    output logic                            last
);
    import rlwf_pkg::*;

    cmd_t                 cmd_reg;
    logic                 busy_reg, busy_next;
    logic [LED_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 oval_reg, oval_next;
    logic [LED_IDX_W-1:0] oidx_reg;
    logic [LEVEL_W-1:0]   ored_reg, ogrn_reg, oblu_reg;
    logic                 olast_reg;

    logic                 out_load;
    logic                 emit;
    logic                 emit_last;
    logic [LED_IDX_W-1:0] emit_idx;

    assign out_load  = !oval_reg || pop;
    assign emit      = busy_reg && out_load;
    assign emit_idx  = cmd_reg.bcast ? cnt_reg : cmd_reg.index;
    assign emit_last = !cmd_reg.bcast || (cnt_reg == LED_IDX_W'(LED_COUNT - 1));
    assign q_pop     = !q_empty && (!busy_reg || (emit && emit_last));

    // Advance the LED counter and the output valid flag
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        oval_next = oval_reg;
        if (emit)
        begin
            cnt_next  = emit_last ? '0 : cnt_reg + 1'b1;
            busy_next = !emit_last;
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        if (emit)
            oval_next = 1'b1;
        else if (pop)
            oval_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            oval_reg <= oval_next;
        end
    end

    // Hold the current command and the output word
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= head_cmd;
        if (emit)
        begin
            oidx_reg  <= emit_idx;
            ored_reg  <= cmd_reg.red;
            ogrn_reg  <= cmd_reg.green;
            oblu_reg  <= cmd_reg.blue;
            olast_reg <= emit_last;
        end
    end

    assign empty     = !oval_reg;
    assign led_index = oidx_reg;
    assign red       = ored_reg;
    assign green     = ogrn_reg;
    assign blue      = oblu_reg;
    assign last      = olast_reg;

endmodule

/* rtl/rgb_led_wipe_fade_sequencer.sv */
// ----------------------------------------------------------------------------
// RGB LED wipe/fade sequencer
// Start-up light show for a string of RGB LEDs: three wipe passes, then fades.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive tick on push while full is low; each word is one tick
//   (tick = 0 words are taken and have no effect). Every TICK_DIVIDE-th tick
//   is an action.
//   Result queue: while empty is low, led_index/red/green/blue/last show the
//   oldest LED word; pop takes it. A wipe action gives one word (none at the
//   end of a pass), a fade action gives LED_COUNT words with last set on the final one.
//   Config port: cfg_we writes cfg_data into register cfg_index (0 fade_peak,
//   1 wipe_level) at the clock edge. The user must write only while the block is idle; the block does not enforce it.
// Timing:
//   An input word is taken every cycle while the command queue has room;
//   the first LED word of an action passes the command queue, the command register and the output register.
//   The back end emits one LED word per cycle while the receiver keeps popping,
//   so a fade action gives LED_COUNT words (38 by default) in a row; back-to-back
//   actions are chained with no gap.
// Reset and stall:
//   Reset clears the show to the red wipe at LED 0 and loads the register
//   defaults. If the receiver stops popping, the output register holds its
//   word, the command queue fills, and full then holds off the input side.
// ----------------------------------------------------------------------------
module rgb_led_wipe_fade_sequencer #(
    parameter int LED_COUNT   = rlwf_pkg::LED_COUNT_DEF,
    parameter int TICK_DIVIDE = rlwf_pkg::TICK_DIVIDE_DEF,
    parameter int CMD_DEPTH   = rlwf_pkg::CMD_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             tick,
    output logic                             empty,
    input  logic                             pop,
    output logic [rlwf_pkg::LED_IDX_W-1:0]   led_index,
    output logic [rlwf_pkg::LEVEL_W-1:0]     red,
    output logic [rlwf_pkg::LEVEL_W-1:0]     green,
    output logic [rlwf_pkg::LEVEL_W-1:0]     blue,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [rlwf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlwf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rlwf_pkg::*;

    `include "rgb_led_wipe_fade_sequencer_defines.svh"

    logic [LEVEL_W-1:0] fade_peak_reg;
    logic [LEVEL_W-1:0] wipe_level_reg;

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    logic q_full, q_empty, q_pop;
    cmd_t head_cmd;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_peak_reg  <= FADE_PEAK_RST;
            wipe_level_reg <= WIPE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FADE_PEAK:  fade_peak_reg  <= cfg_data;
                REG_WIPE_LEVEL: wipe_level_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    rlwf_front #(
        .LED_COUNT   (LED_COUNT),
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .tick       (tick),
        .fade_peak  (fade_peak_reg),
        .wipe_level (wipe_level_reg),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    rlwf_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    rlwf_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last)
    );

    // Checks
    `RLWF_ASSERT_NEVER(a_queue_full_empty, clk, rst_n, q_full && q_empty, "queue full and empty")
    `RLWF_ASSERT_IMPL(a_index_range, clk, rst_n, !empty, {1'b0, led_index} < (LED_IDX_W+1)'(LED_COUNT), "LED index out of range")
    `RLWF_ASSERT_IMPL(a_mid_word, clk, rst_n, !empty && !last, led_index < LED_IDX_W'(LED_COUNT - 1), "non-final word at last LED")
    `RLWF_ASSERT_IMPL(a_pop_source, clk, rst_n, q_pop, !q_empty, "pop from empty command queue")

endmodule
